// File: design/v210yc_pkg.sv
// ---------------------------------------------------------------------------
// v210yc_pkg
// shared types, constants and register codes of the v210 to rgb converter
// ---------------------------------------------------------------------------
package v210yc_pkg;

   // default sizing, used as the defaults of the top level parameters
   localparam int MAX_PIXELS_DEF     = 4096;
   localparam int COEF_FRAC_BITS_DEF = 13;

   // fixed field widths
   localparam int WORD_W   = 32;
   localparam int COMP_BW  = 10;
   localparam int CHAN_W   = 8;
   localparam int APIX_W   = 13;
   localparam int WPL_W    = 12;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 13;
   localparam int RSP_DAT_W = 6 * CHAN_W;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_PIXELS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WORDS_PER_LINE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_SET      = 2'd2;

   // register reset values
   localparam logic [APIX_W-1:0] ACTIVE_PIXELS_RST  = 13'd720;
   localparam logic [WPL_W-1:0]  WORDS_PER_LINE_RST = 12'd480;
   localparam logic              COEFF_SET_RST      = 1'b1;

   // one completed 4:2:2 group, cb/cr still offset binary
   typedef struct packed {
      logic [COMP_BW-1:0] cb;
      logic [COMP_BW-1:0] y0;
      logic [COMP_BW-1:0] cr;
      logic [COMP_BW-1:0] y1;
      logic               line_end;
   } v210yc_group_type;

endpackage

// File: design/v210_ycbcr422_to_rgb_core.sv
// ---------------------------------------------------------------------------
// v210_ycbcr422_to_rgb_core
// unpacks v210 4:2:2 words and converts each cb/y0/cr/y1 group to two rgb888 pixels
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------------
//  req      | in        | req_tvalid/req_tready | req_tdata: packed_word (32 bit)
//  rsp      | out       | rsp_tvalid/rsp_tready | rsp_tdata: rgb pair, rsp_tlast: line_end
//  csr      | in        | csr_wr_en             | csr_index, csr_wdata
//
//  one word is taken every clock while the output side keeps up; a word that
//  completes a group gives one item by way of the group register, the product
//  register and the output register
//  the matrix stages stall together on rsp_tready; words that complete no group
//  still pass freely while the group register is free
//  synchronous active high reset clears the line counters, stage valids and
//  loads the register defaults (720 pixels, 480 words, second coefficient set)
//
module v210_ycbcr422_to_rgb_core #(
   parameter int MAX_PIXELS     = v210yc_pkg::MAX_PIXELS_DEF,
   parameter int COEF_FRAC_BITS = v210yc_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [v210yc_pkg::WORD_W-1:0]       req_tdata,  // [31:0] packed_word
   // result items
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] red_first, [15:8] green_first, [23:16] blue_first,
   // [31:24] red_second, [39:32] green_second, [47:40] blue_second
   output logic [v210yc_pkg::RSP_DAT_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast,  // line_end
   // register writes
   input  logic                                csr_wr_en,
   input  logic [v210yc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [v210yc_pkg::CSR_DAT_W-1:0]    csr_wdata
);
   import v210yc_pkg::*;

   // configuration registers
   logic [APIX_W-1:0] apix_ff;
   logic [WPL_W-1:0]  wpl_ff;
   logic              cset_ff;

   // group register to matrix
   logic              grp_valid, grp_ready;
   v210yc_group_type  grp;

   always_ff @(posedge clock) begin
      if (reset) begin
         apix_ff <= ACTIVE_PIXELS_RST;
         wpl_ff  <= WORDS_PER_LINE_RST;
         cset_ff <= COEFF_SET_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ACTIVE_PIXELS:  apix_ff <= csr_wdata[APIX_W-1:0];
            CSR_WORDS_PER_LINE: wpl_ff  <= csr_wdata[WPL_W-1:0];
            CSR_COEFF_SET:      cset_ff <= csr_wdata[0];
            default: ;  // unmapped index, write ignored
         endcase
      end
   end

   // line position, padding skip and grouping of components
   v210yc_unpack #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_unpack (
      .clock          (clock),
      .reset          (reset),
      .active_pixels  (apix_ff),
      .words_per_line (wpl_ff),
      .word_valid     (req_tvalid),
      .word_ready     (req_tready),
      .word           (req_tdata),
      .grp_valid      (grp_valid),
      .grp_ready      (grp_ready),
      .grp            (grp)
   );

   // colour matrix; the user must change the coefficient set only while idle, the block does not enforce this
   v210yc_matrix #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_matrix (
      .clock      (clock),
      .reset      (reset),
      .coeff_set  (cset_ff),
      .grp_valid  (grp_valid),
      .grp_ready  (grp_ready),
      .grp        (grp),
      .pix_valid  (rsp_tvalid),
      .pix_ready  (rsp_tready),
      .pix_data   (rsp_tdata),
      .pix_last   (rsp_tlast)
   );

endmodule

// File: design/v210yc_unpack.sv
// ---------------------------------------------------------------------------
// v210yc_unpack
// line position tracking and component grouping for v210 words
// ---------------------------------------------------------------------------
module v210yc_unpack #(
   parameter int MAX_PIXELS = v210yc_pkg::MAX_PIXELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [v210yc_pkg::APIX_W-1:0]     active_pixels,
   input  logic [v210yc_pkg::WPL_W-1:0]      words_per_line,
   input  logic                              word_valid,
   output logic                              word_ready,
   input  logic [v210yc_pkg::WORD_W-1:0]     word,
   output logic                              grp_valid,
   input  logic                              grp_ready,
   output v210yc_pkg::v210yc_group_type      grp
);
   import v210yc_pkg::*;

   localparam int PIX_W  = $clog2(MAX_PIXELS + 1);
   localparam int COMP_W = PIX_W + 1;
   localparam int CMP_W  = (APIX_W + 1 > PIX_W) ? APIX_W + 1 : PIX_W;

   logic [WPL_W-1:0]   word_ff, word_in;
   logic [COMP_W-1:0]  cnt_ff, cnt_in;
   logic [COMP_BW-1:0] held_ff [3];
   logic [COMP_BW-1:0] held_in [3];
   logic               grp_vld_ff, grp_vld_in;
   v210yc_group_type   grp_ff, grp_in;

   logic [CMP_W-1:0]   apix_ext, pix_cl;
   logic [COMP_W-1:0]  limit;
   logic [COMP_W:0]    idx [3];
   logic [2:0]         take;
   logic [COMP_BW-1:0] comp [3];
   logic [WPL_W:0]     word_sum;
   logic               wrap, accept, has_res;

   assign accept     = word_valid && word_ready;
   assign word_ready = !grp_vld_ff || grp_ready;

   // clamp active pixels to the build limit
   assign apix_ext = CMP_W'(active_pixels);
   assign pix_cl   = (apix_ext > CMP_W'(MAX_PIXELS)) ? CMP_W'(MAX_PIXELS) : apix_ext;
   assign limit    = {pix_cl[PIX_W-1:0], 1'b0};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         comp[i] = word[COMP_BW*i +: COMP_BW];
         idx[i]  = (COMP_W+1)'(cnt_ff) + (COMP_W+1)'(i);
         take[i] = idx[i] < (COMP_W+1)'(limit);
      end
   end

   // grouping by phase of the component count
   always_comb begin
      for (int k = 0; k < 3; k++) held_in[k] = held_ff[k];
      grp_in  = grp_ff;
      has_res = 1'b0;
      case (cnt_ff[1:0])
         2'd0: begin
            if (take[0]) held_in[0] = comp[0];
            if (take[1]) held_in[1] = comp[1];
            if (take[2]) held_in[2] = comp[2];
         end
         2'd1: begin
            if (take[0]) held_in[1] = comp[0];
            if (take[1]) held_in[2] = comp[1];
            has_res     = take[2];
            grp_in.cb   = held_ff[0];
            grp_in.y0   = comp[0];
            grp_in.cr   = comp[1];
            grp_in.y1   = comp[2];
            grp_in.line_end = (idx[2] + 1'b1) == (COMP_W+1)'(limit);
         end
         2'd2: begin
            if (take[0]) held_in[2] = comp[0];
            if (take[2]) held_in[0] = comp[2];
            has_res     = take[1];
            grp_in.cb   = held_ff[0];
            grp_in.y0   = held_ff[1];
            grp_in.cr   = comp[0];
            grp_in.y1   = comp[1];
            grp_in.line_end = (idx[1] + 1'b1) == (COMP_W+1)'(limit);
         end
         default: begin
            if (take[1]) held_in[0] = comp[1];
            if (take[2]) held_in[1] = comp[2];
            has_res     = take[0];
            grp_in.cb   = held_ff[0];
            grp_in.y0   = held_ff[1];
            grp_in.cr   = held_ff[2];
            grp_in.y1   = comp[0];
            grp_in.line_end = (idx[0] + 1'b1) == (COMP_W+1)'(limit);
         end
      endcase
   end

   // line wrap after the last word, padding included
   assign word_sum = (WPL_W+1)'(word_ff) + 1'b1;
   assign wrap     = word_sum >= (WPL_W+1)'(words_per_line);

   always_comb begin
      word_in = wrap ? '0 : word_sum[WPL_W-1:0];
      cnt_in  = cnt_ff + COMP_W'(take[0]) + COMP_W'(take[1]) + COMP_W'(take[2]);
      if (wrap) cnt_in = '0;
      grp_vld_in = grp_vld_ff;
      if (word_ready) grp_vld_in = accept && has_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff    <= '0;
         cnt_ff     <= '0;
         grp_vld_ff <= 1'b0;
      end else begin
         grp_vld_ff <= grp_vld_in;
         if (accept) begin
            word_ff <= word_in;
            cnt_ff  <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < 3; k++) held_ff[k] <= held_in[k];
         if (has_res) grp_ff <= grp_in;
      end
   end

   assign grp_valid = grp_vld_ff;
   assign grp       = grp_ff;

endmodule

// File: design/v210yc_matrix.sv
// ---------------------------------------------------------------------------
// v210yc_matrix
// ycbcr to rgb colour matrix, two pixels per group, clamped to 8 bits
// ---------------------------------------------------------------------------
module v210yc_matrix #(
   parameter int COEF_FRAC_BITS = v210yc_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               coeff_set,
   input  logic                               grp_valid,
   output logic                               grp_ready,
   input  v210yc_pkg::v210yc_group_type       grp,
   output logic                               pix_valid,
   input  logic                               pix_ready,
   output logic [v210yc_pkg::RSP_DAT_W-1:0]   pix_data,
   output logic                               pix_last
);
   import v210yc_pkg::*;

   localparam int COEF_W = COEF_FRAC_BITS + 1;
   localparam int PROD_W = COEF_W + COMP_BW + 1;
   localparam int SUM_W  = COEF_FRAC_BITS + 13;
   localparam int SH_W   = SUM_W - COEF_FRAC_BITS - 2;

   localparam longint A_F1 = (longint'(1402)  << COEF_FRAC_BITS) / 1000;
   localparam longint A_F2 = (longint'(34414) << COEF_FRAC_BITS) / 100000;
   localparam longint A_F3 = (longint'(71414) << COEF_FRAC_BITS) / 100000;
   localparam longint A_F4 = (longint'(1772)  << COEF_FRAC_BITS) / 1000;
   localparam longint B_F1 = (longint'(15748) << COEF_FRAC_BITS) / 10000;
   localparam longint B_F2 = (longint'(1874)  << COEF_FRAC_BITS) / 10000;
   localparam longint B_F3 = (longint'(4681)  << COEF_FRAC_BITS) / 10000;
   localparam longint B_F4 = (longint'(18560) << COEF_FRAC_BITS) / 10000;

   function automatic logic [CHAN_W-1:0] clamp_px(input logic signed [SUM_W-1:0] s);
      logic [SH_W-1:0] v;
      v = s[SUM_W-1:COEF_FRAC_BITS+2];
      if (s[SUM_W-1])            return '0;
      else if (|v[SH_W-1:CHAN_W]) return '1;
      else                        return v[CHAN_W-1:0];
   endfunction

   // products stage
   logic                      prd_vld_ff;
   logic [COMP_BW-1:0]        ya_ff, yb_ff;
   logic signed [PROD_W-1:0]  p_r_ff, p_gb_ff, p_gr_ff, p_b_ff;
   logic                      last_p_ff;
   logic signed [COEF_W:0]    f1, f2, f3, f4;
   logic signed [COMP_BW-1:0] cb_s, cr_s;
   logic                      prd_ready;

   // output stage
   logic                      out_vld_ff;
   logic [RSP_DAT_W-1:0]      out_data_ff, out_data_in;
   logic                      out_last_ff;
   logic                      out_ready;
   logic signed [SUM_W-1:0]   ya_w, yb_w, r_c, g_c, b_c;

   assign out_ready = !out_vld_ff || pix_ready;
   assign prd_ready = !prd_vld_ff || out_ready;
   assign grp_ready = prd_ready;

   // offset binary to two's complement: flip the top bit
   assign cb_s = {~grp.cb[COMP_BW-1], grp.cb[COMP_BW-2:0]};
   assign cr_s = {~grp.cr[COMP_BW-1], grp.cr[COMP_BW-2:0]};

   always_comb begin
      if (coeff_set) begin
         f1 = {1'b0, COEF_W'(B_F1)};
         f2 = {1'b0, COEF_W'(B_F2)};
         f3 = {1'b0, COEF_W'(B_F3)};
         f4 = {1'b0, COEF_W'(B_F4)};
      end else begin
         f1 = {1'b0, COEF_W'(A_F1)};
         f2 = {1'b0, COEF_W'(A_F2)};
         f3 = {1'b0, COEF_W'(A_F3)};
         f4 = {1'b0, COEF_W'(A_F4)};
      end
   end

   // shared chroma terms, luma scaled by the fraction
   assign ya_w = $signed({3'b000, ya_ff, {COEF_FRAC_BITS{1'b0}}});
   assign yb_w = $signed({3'b000, yb_ff, {COEF_FRAC_BITS{1'b0}}});
   assign r_c  = SUM_W'(p_r_ff);
   assign g_c  = -SUM_W'(p_gb_ff) - SUM_W'(p_gr_ff);
   assign b_c  = SUM_W'(p_b_ff);

   assign out_data_in = {clamp_px(yb_w + b_c), clamp_px(yb_w + g_c), clamp_px(yb_w + r_c),
                         clamp_px(ya_w + b_c), clamp_px(ya_w + g_c), clamp_px(ya_w + r_c)};

   always_ff @(posedge clock) begin
      if (reset) begin
         prd_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (prd_ready) prd_vld_ff <= grp_valid;
         if (out_ready) out_vld_ff <= prd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (prd_ready && grp_valid) begin
         ya_ff     <= grp.y0;
         yb_ff     <= grp.y1;
         p_r_ff    <= PROD_W'(f1 * cr_s);
         p_gb_ff   <= PROD_W'(f2 * cb_s);
         p_gr_ff   <= PROD_W'(f3 * cr_s);
         p_b_ff    <= PROD_W'(f4 * cb_s);
         last_p_ff <= grp.line_end;
      end
      if (out_ready && prd_vld_ff) begin
         out_data_ff <= out_data_in;
         out_last_ff <= last_p_ff;
      end
   end

   assign pix_valid = out_vld_ff;
   assign pix_data  = out_data_ff;
   assign pix_last  = out_last_ff;

endmodule
